/* hdl/twns_pkg.sv */
`default_nettype none
// ============================================================================
// twns_pkg: shared types and constants of the texture sampler
// Sequencer state encoding, configuration register indexes, operation codes
// and the fixed field widths of the item and configuration ports.
// ============================================================================
package twns_pkg;

    // Fixed field widths of the ports.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SIZE_W     = 9;
    localparam int BASE_W     = 16;
    localparam int COORD_W    = 32;
    localparam int SHIFT_W    = 10;
    localparam int INDEX_W    = 16;
    localparam int TEXEL_W    = 32;
    localparam int CHAN_W     = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_BASE = 2'd2;

    // Operation codes of an input item.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_MUL_X  = 14'b00000000000010,
        ST_LOAD_X = 14'b00000000000100,
        ST_MOD_X  = 14'b00000000001000,
        ST_MUL_Y  = 14'b00000000010000,
        ST_LOAD_Y = 14'b00000000100000,
        ST_MOD_Y  = 14'b00000001000000,
        ST_MUL_A  = 14'b00000010000000,
        ST_SUM_A  = 14'b00000100000000,
        ST_MOD_A  = 14'b00001000000000,
        ST_READ   = 14'b00010000000000,
        ST_DONE   = 14'b00100000000000,
        ST_MOD_W  = 14'b01000000000000,
        ST_WRITE  = 14'b10000000000000
    } state_t;

endpackage
`default_nettype wire

/* hdl/twns_ram.sv */
`default_nettype none
// ============================================================================
// twns_ram: generic single-port-write, single-port-read memory
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ============================================================================
module twns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* hdl/texture_wrap_nearest_sampler_core.sv */
// A sample's address passes through the remainder unit only when TEXEL_DEPTH
// is not a power of two.
// Throughput: one item at a time; the bit-serial remainder unit sets the pace.
// Reset: asynchronous, active low; clears the sequencer, output valid and the
// configuration registers. The texel memory is not cleared.
`default_nettype none
// ============================================================================
// texture_wrap_nearest_sampler_core: nearest-neighbor texture sampler
// Samples a packed RGBA texture held in a texel memory with repeat wrapping
// on both axes. Write items fill the memory; sample items return one texel.
// ============================================================================
module texture_wrap_nearest_sampler_core #(
    parameter int TEXEL_DEPTH = 65536,
    parameter int SIDE_MAX    = 256,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [twns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [twns_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input item channel.
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic                              operation,
    input  wire logic signed [twns_pkg::COORD_W-1:0] u_coord,
    input  wire logic signed [twns_pkg::COORD_W-1:0] v_coord,
    input  wire logic [twns_pkg::SHIFT_W-1:0]      shift_u,
    input  wire logic [twns_pkg::SHIFT_W-1:0]      shift_v,
    input  wire logic [twns_pkg::INDEX_W-1:0]      write_index,
    input  wire logic [twns_pkg::TEXEL_W-1:0]      write_texel,
    // Result item channel.
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [twns_pkg::CHAN_W-1:0]       red,
    output      logic [twns_pkg::CHAN_W-1:0]       green,
    output      logic [twns_pkg::CHAN_W-1:0]       blue,
    output      logic [twns_pkg::CHAN_W-1:0]       alpha
);

    import twns_pkg::*;

    // ------------------------------------------------------------------------
    // Derived widths.
    // ------------------------------------------------------------------------
    localparam int ADDR_W     = $clog2(TEXEL_DEPTH);
    localparam int SIDE_W     = $clog2(SIDE_MAX + 1);
    localparam int CMP_W      = (SIDE_W > SIZE_W) ? SIDE_W : SIZE_W;
    localparam int MUL_A_W    = (FRAC_BITS > SIDE_W) ? FRAC_BITS : SIDE_W;
    localparam int MUL_W      = MUL_A_W + SIDE_W;
    // Wrapped coordinate plus offset stays below SIDE_MAX + 1024.
    localparam int AX_SUM_W   = $clog2(SIDE_MAX + 1024);
    // Base plus y*width plus x stays below 65536 + SIDE_MAX*SIDE_MAX.
    localparam int ADDR_SUM_W = $clog2(65536 + SIDE_MAX * SIDE_MAX);
    localparam int MAX_MOD    = (SIDE_MAX > TEXEL_DEPTH) ? SIDE_MAX : TEXEL_DEPTH;
    localparam int MOD_W      = $clog2(MAX_MOD + 1);
    localparam int DIV_W0     = (AX_SUM_W > ADDR_SUM_W) ? AX_SUM_W : ADDR_SUM_W;
    localparam int DIV_W      = (DIV_W0 > INDEX_W) ? DIV_W0 : INDEX_W;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int AX_ALIGN   = DIV_W - AX_SUM_W;
    localparam int ADDR_ALIGN = DIV_W - ADDR_SUM_W;
    localparam int IDX_ALIGN  = DIV_W - INDEX_W;

    // A power-of-two memory depth wraps addresses by truncation. Otherwise the
    // remainder unit reduces them, and a write index needs it only when it can
    // reach past the depth.
    localparam bit DEPTH_POW2   = ((TEXEL_DEPTH & (TEXEL_DEPTH - 1)) == 0);
    localparam bit NEED_IDX_MOD = !DEPTH_POW2 && (TEXEL_DEPTH < 65536);

    // Zero means one texel; anything past SIDE_MAX is held at SIDE_MAX.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIZE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        begin
            if (s == '0)
            begin
                r = SIDE_W'(1);
            end
            else if (CMP_W'(s) > CMP_W'(SIDE_MAX))
            begin
                r = SIDE_W'(SIDE_MAX);
            end
            else
            begin
                r = SIDE_W'(s);
            end
            return r;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic [SIZE_W-1:0] tex_width_reg;
    logic [SIZE_W-1:0] tex_height_reg;
    logic [BASE_W-1:0] texel_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= SIZE_W'(1);
            tex_height_reg <= SIZE_W'(1);
            texel_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEX_WIDTH:  tex_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_TEX_HEIGHT: tex_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_TEXEL_BASE: texel_base_reg <= cfg_data[BASE_W-1:0];
                default:        ;
            endcase
        end
    end

    logic [SIDE_W-1:0] w_eff;
    logic [SIDE_W-1:0] h_eff;

    assign w_eff = clamp_side(tex_width_reg);
    assign h_eff = clamp_side(tex_height_reg);

    // ------------------------------------------------------------------------
    // Sequencer and item holding registers.
    // ------------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic                 in_accept;
    logic                 out_accept;
    logic                 out_load;

    logic [FRAC_BITS-1:0] fu_reg;
    logic [FRAC_BITS-1:0] fv_reg;
    logic [SHIFT_W-1:0]   su_reg;
    logic [SHIFT_W-1:0]   sv_reg;
    logic [TEXEL_W-1:0]   wtexel_reg;
    logic [SIDE_W-1:0]    x_reg;
    logic [SIDE_W-1:0]    y_reg;
    logic [ADDR_W-1:0]    addr_reg;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    // The result register frees up in the same cycle it is taken.
    assign out_load   = (state_reg == ST_DONE) && (!out_valid || !out_stall);
    assign in_stall   = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------------
    // Shared multiplier: fraction times size for each axis, then row times
    // width for the address. The product is always registered.
    // ------------------------------------------------------------------------
    logic [MUL_A_W-1:0] mul_a;
    logic [SIDE_W-1:0]  mul_b;
    logic [MUL_W-1:0]   mul_reg;
    logic [SIDE_W-1:0]  whole;

    always_comb
    begin
        case (state_reg)
            ST_MUL_X:
            begin
                mul_a = MUL_A_W'(fu_reg);
                mul_b = w_eff;
            end
            ST_MUL_Y:
            begin
                mul_a = MUL_A_W'(fv_reg);
                mul_b = h_eff;
            end
            default:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = w_eff;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    // Shifting out the fraction bits truncates the scaled coordinate.
    assign whole = mul_reg[FRAC_BITS +: SIDE_W];

    // ------------------------------------------------------------------------
    // Shared remainder unit: restoring reduction, one dividend bit per cycle,
    // dividend loaded left-aligned so only its meaningful bits are stepped.
    // ------------------------------------------------------------------------
    logic                 mod_load;
    logic [DIV_W-1:0]     mod_div_in;
    logic [CNT_W-1:0]     mod_cnt_in;
    logic [MOD_W-1:0]     mod_m_in;
    logic                 mod_step;

    logic [DIV_W-1:0]     div_sh_reg;
    logic [MOD_W-1:0]     rem_reg;
    logic [MOD_W-1:0]     mod_m_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [MOD_W:0]       trial;
    logic [MOD_W-1:0]     rem_next;
    logic                 mod_last;

    logic [AX_SUM_W-1:0]   ax_sum;
    logic [ADDR_SUM_W-1:0] addr_sum;

    assign ax_sum   = AX_SUM_W'(whole)
                    + AX_SUM_W'((state_reg == ST_LOAD_X) ? su_reg : sv_reg);
    assign addr_sum = ADDR_SUM_W'(texel_base_reg) + ADDR_SUM_W'(mul_reg)
                    + ADDR_SUM_W'(x_reg);

    assign trial    = {rem_reg, div_sh_reg[DIV_W-1]};
    assign rem_next = (trial >= {1'b0, mod_m_reg})
                    ? MOD_W'(trial - {1'b0, mod_m_reg})
                    : trial[MOD_W-1:0];
    assign mod_last = (cnt_reg == '0);
    assign mod_step = (state_reg == ST_MOD_X) || (state_reg == ST_MOD_Y)
                   || (state_reg == ST_MOD_A) || (state_reg == ST_MOD_W);

    always_comb
    begin
        mod_load   = 1'b0;
        mod_div_in = DIV_W'(ax_sum) << AX_ALIGN;
        mod_cnt_in = CNT_W'(AX_SUM_W - 1);
        mod_m_in   = MOD_W'((state_reg == ST_LOAD_X) ? w_eff : h_eff);
        case (state_reg)
            ST_IDLE:
            begin
                mod_load   = in_accept && (operation == OP_WRITE) && NEED_IDX_MOD;
                mod_div_in = DIV_W'(write_index) << IDX_ALIGN;
                mod_cnt_in = CNT_W'(INDEX_W - 1);
                mod_m_in   = MOD_W'(TEXEL_DEPTH);
            end
            ST_LOAD_X, ST_LOAD_Y:
            begin
                mod_load = 1'b1;
            end
            ST_SUM_A:
            begin
                mod_load   = !DEPTH_POW2;
                mod_div_in = DIV_W'(addr_sum) << ADDR_ALIGN;
                mod_cnt_in = CNT_W'(ADDR_SUM_W - 1);
                mod_m_in   = MOD_W'(TEXEL_DEPTH);
            end
            default:
            begin
                mod_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mod_load)
        begin
            div_sh_reg <= mod_div_in;
            rem_reg    <= '0;
            mod_m_reg  <= mod_m_in;
            cnt_reg    <= mod_cnt_in;
        end
        else if (mod_step)
        begin
            div_sh_reg <= div_sh_reg << 1;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_reg - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // State transitions.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == OP_SAMPLE)
                    begin
                        state_next = ST_MUL_X;
                    end
                    else if (NEED_IDX_MOD)
                    begin
                        state_next = ST_MOD_W;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_MUL_X:  state_next = ST_LOAD_X;
            ST_LOAD_X: state_next = ST_MOD_X;
            ST_MOD_X:
            begin
                if (mod_last)
                begin
                    state_next = ST_MUL_Y;
                end
            end
            ST_MUL_Y:  state_next = ST_LOAD_Y;
            ST_LOAD_Y: state_next = ST_MOD_Y;
            ST_MOD_Y:
            begin
                if (mod_last)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:  state_next = ST_SUM_A;
            ST_SUM_A:  state_next = DEPTH_POW2 ? ST_READ : ST_MOD_A;
            ST_MOD_A:
            begin
                if (mod_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOD_W:
            begin
                if (mod_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload capture and intermediate results.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fu_reg     <= u_coord[FRAC_BITS-1:0];
            fv_reg     <= v_coord[FRAC_BITS-1:0];
            su_reg     <= shift_u;
            sv_reg     <= shift_v;
            wtexel_reg <= write_texel;
            addr_reg   <= ADDR_W'(write_index);
        end
        if ((state_reg == ST_MOD_X) && mod_last)
        begin
            x_reg <= rem_next[SIDE_W-1:0];
        end
        if ((state_reg == ST_MOD_Y) && mod_last)
        begin
            y_reg <= rem_next[SIDE_W-1:0];
        end
        if (state_reg == ST_SUM_A)
        begin
            addr_reg <= ADDR_W'(addr_sum);
        end
        if (((state_reg == ST_MOD_A) || (state_reg == ST_MOD_W)) && mod_last)
        begin
            addr_reg <= ADDR_W'(rem_next);
        end
    end

    // ------------------------------------------------------------------------
    // Texel memory. Writes and reads never share a cycle, and a sample's read
    // always comes after every earlier write has landed.
    // ------------------------------------------------------------------------
    logic [TEXEL_W-1:0] ram_rdata;
    logic               ram_we;
    logic               ram_re;

    assign ram_we = (state_reg == ST_WRITE);
    assign ram_re = (state_reg == ST_READ);

    twns_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (TEXEL_DEPTH)
    ) u_texel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wtexel_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Result register: holds one finished item so the sequencer can go back
    // to idle and take the next item while the result waits downstream.
    // ------------------------------------------------------------------------
    logic               out_valid_reg;
    logic [TEXEL_W-1:0] texel_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            texel_out_reg <= ram_rdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = texel_out_reg[7:0];
    assign green     = texel_out_reg[15:8];
    assign blue      = texel_out_reg[23:16];
    assign alpha     = texel_out_reg[31:24];

endmodule
`default_nettype wire

/* hdl/twns_checker.sv */
`default_nettype none
// ============================================================================
// twns_checker: port-level checks for the texture sampler
// Watches the item channels over time; attached to the top level by bind.
// ============================================================================
module twns_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              operation,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [twns_pkg::CHAN_W-1:0]       red,
    input wire logic [twns_pkg::CHAN_W-1:0]       green,
    input wire logic [twns_pkg::CHAN_W-1:0]       blue,
    input wire logic [twns_pkg::CHAN_W-1:0]       alpha
);

    import twns_pkg::*;

    logic in_take;

    assign in_take = in_valid && !in_stall;

    // The block works on one item at a time, so it stalls right after a take.
    a_busy_after_take: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall
    ) else $error("input not stalled after an item was taken");

    // A write item produces no result while no earlier result is pending.
    a_write_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_take && (operation == OP_WRITE) && !out_valid) |=> !out_valid ##1 !out_valid
    ) else $error("result appeared for a write item");

    // A result is loaded only as the sequencer returns to idle.
    a_result_at_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall
    ) else $error("result appeared while the sequencer was busy");

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha))
    ) else $error("stalled result changed");

endmodule

bind texture_wrap_nearest_sampler_core twns_checker u_twns_checker (.*);
`default_nettype wire

/* test/tb_texture_wrap_nearest_sampler_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_texture_wrap_nearest_sampler_core: self-checking bench of the sampler
// Fills the texel memory and samples it under a series of texture settings.
// A scoreboard class keeps its own copy of the memory and of the registers,
// works out the texel that each sample must return, and compares the result
// channel by channel while both handshakes idle and stall at random.
// ============================================================================
module tb_texture_wrap_nearest_sampler_core;
    import twns_pkg::*;

    localparam int FRAC         = 16;
    localparam int SIDE_LIMIT   = 256;
    localparam int MEM_DEPTH    = 65536;
    localparam int ITEM_TARGET  = 1350;
    localparam int PHASES       = 10;
    // Margin left after the last answer before the registers are touched.
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 1000000;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the texel memory and of the three texture
    // registers, plus the queue of texels that samples still owe us.
    // ------------------------------------------------------------------------
    class texel_scoreboard;
        bit [TEXEL_W-1:0] texel_mem [MEM_DEPTH];
        bit [SIZE_W-1:0]  width_reg;
        bit [SIZE_W-1:0]  height_reg;
        bit [BASE_W-1:0]  base_reg;
        bit [TEXEL_W-1:0] expected_texels [$];
        int               mismatches;

        function new();
            width_reg  = 1;
            height_reg = 1;
            base_reg   = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_TEX_WIDTH:  width_reg  = data[SIZE_W-1:0];
                CFG_TEX_HEIGHT: height_reg = data[SIZE_W-1:0];
                CFG_TEXEL_BASE: base_reg   = data[BASE_W-1:0];
                default: ;
            endcase
        endfunction

        // A size of zero counts as one texel, and sizes past the limit are clamped.
        function bit [SIZE_W-1:0] side(bit [SIZE_W-1:0] s);
            if (s == 0)
                return 1;
            if (s > SIDE_LIMIT)
                return SIZE_W'(SIDE_LIMIT);
            return s;
        endfunction

        function int area();
            return int'(side(width_reg)) * int'(side(height_reg));
        endfunction

        // The low fraction bits are coord - floor(coord) even for negative
        // values; scale them by the size, truncate, add the offset and wrap.
        function bit [SIZE_W-1:0] wrap_axis(bit [COORD_W-1:0] coord,
                                            bit [SHIFT_W-1:0] offs,
                                            bit [SIZE_W-1:0] size);
            bit [FRAC+SIZE_W-1:0] scaled;
            bit [SHIFT_W:0]       sum;
            scaled = (FRAC+SIZE_W)'(coord[FRAC-1:0]) * (FRAC+SIZE_W)'(size);
            sum = (SHIFT_W+1)'(scaled[FRAC+SIZE_W-1:FRAC]) + (SHIFT_W+1)'(offs);
            return SIZE_W'(sum % (SHIFT_W+1)'(size));
        endfunction

        function bit [INDEX_W-1:0] texel_addr(bit [COORD_W-1:0] u, bit [COORD_W-1:0] v,
                                              bit [SHIFT_W-1:0] su, bit [SHIFT_W-1:0] sv);
            bit [SIZE_W-1:0] w;
            bit [SIZE_W-1:0] h;
            bit [SIZE_W-1:0] x;
            bit [SIZE_W-1:0] y;
            bit [31:0]       flat;
            w = side(width_reg);
            h = side(height_reg);
            x = wrap_axis(u, su, w);
            y = wrap_axis(v, sv, h);
            flat = 32'(base_reg) + 32'(y) * 32'(w) + 32'(x);
            return flat[INDEX_W-1:0];
        endfunction

        function void note_item(bit op, bit [COORD_W-1:0] u, bit [COORD_W-1:0] v,
                                bit [SHIFT_W-1:0] su, bit [SHIFT_W-1:0] sv,
                                bit [INDEX_W-1:0] idx, bit [TEXEL_W-1:0] texel);
            if (op == OP_WRITE)
                texel_mem[idx] = texel;
            else
                expected_texels.push_back(texel_mem[texel_addr(u, v, su, sv)]);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH %s", $time, what);
            mismatches++;
        endtask

        task check_result(bit [CHAN_W-1:0] r, bit [CHAN_W-1:0] g,
                          bit [CHAN_W-1:0] b, bit [CHAN_W-1:0] a);
            bit [TEXEL_W-1:0] want;
            if (expected_texels.size() == 0)
            begin
                report_mismatch($sformatf("texel %h arrived with none outstanding",
                                          {a, b, g, r}));
                return;
            end
            want = expected_texels.pop_front();
            if (r != want[7:0])
                report_mismatch($sformatf("red got %h want %h", r, want[7:0]));
            if (g != want[15:8])
                report_mismatch($sformatf("green got %h want %h", g, want[15:8]));
            if (b != want[23:16])
                report_mismatch($sformatf("blue got %h want %h", b, want[23:16]));
            if (a != want[31:24])
                report_mismatch($sformatf("alpha got %h want %h", a, want[31:24]));
        endtask

        function int pending();
            return expected_texels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports.
    // ------------------------------------------------------------------------
    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic                        operation;
    logic signed [COORD_W-1:0]   u_coord;
    logic signed [COORD_W-1:0]   v_coord;
    logic [SHIFT_W-1:0]          shift_u;
    logic [SHIFT_W-1:0]          shift_v;
    logic [INDEX_W-1:0]          write_index;
    logic [TEXEL_W-1:0]          write_texel;
    logic                        out_valid;
    logic                        out_stall;
    logic [CHAN_W-1:0]           red;
    logic [CHAN_W-1:0]           green;
    logic [CHAN_W-1:0]           blue;
    logic [CHAN_W-1:0]           alpha;

    texel_scoreboard sb = new();

    // Entries the stimulus has already filled. A sample is only ever aimed at
    // one of these, since reading a texel that was never written is undefined.
    bit texel_written [MEM_DEPTH];
    bit idle_on    = 1'b1;
    int items_sent = 0;
    int stall_left = 0;
    int cycles     = 0;

    texture_wrap_nearest_sampler_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .shift_u     (shift_u),
        .shift_v     (shift_v),
        .write_index (write_index),
        .write_texel (write_texel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha)
    );

    always #10 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("texture_wrap_nearest_sampler_core verification failed");
            $finish;
        end
    end

    // The result side stalls at random, in bursts, while idling is on.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Both channels are observed at the clock edge, on the values that the
    // block itself samples, so the order of processes within a step is moot.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(operation, u_coord, v_coord, shift_u, shift_v,
                             write_index, write_texel);
            if (out_valid && !out_stall)
                sb.check_result(red, green, blue, alpha);
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Each is entered right after a rising edge and returns at
    // the edge where its last action took effect.
    // ------------------------------------------------------------------------

    // Presents one item and holds it until the block takes it. When idling is
    // on, valid sometimes drops first for a random gap.
    task automatic send_item(bit op, bit [COORD_W-1:0] u, bit [COORD_W-1:0] v,
                             bit [SHIFT_W-1:0] su, bit [SHIFT_W-1:0] sv,
                             bit [INDEX_W-1:0] idx, bit [TEXEL_W-1:0] texel);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        u_coord     <= u;
        v_coord     <= v;
        shift_u     <= su;
        shift_v     <= sv;
        write_index <= idx;
        write_texel <= texel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Coordinates and offsets of a write are ignored, so they carry noise.
    task automatic write_at(bit [INDEX_W-1:0] idx, bit [TEXEL_W-1:0] texel);
        texel_written[idx] = 1'b1;
        send_item(OP_WRITE, $urandom, $urandom, SHIFT_W'($urandom), SHIFT_W'($urandom),
                  idx, texel);
    endtask

    // If the texel the sample lands on has never been written, it is filled
    // right before, which also checks that a fresh write is seen at once.
    task automatic sample_at(bit [COORD_W-1:0] u, bit [COORD_W-1:0] v,
                             bit [SHIFT_W-1:0] su, bit [SHIFT_W-1:0] sv);
        bit [INDEX_W-1:0] addr;
        addr = sb.texel_addr(u, v, su, sv);
        if (!texel_written[addr])
            write_at(addr, $urandom);
        send_item(OP_SAMPLE, u, v, su, sv, INDEX_W'($urandom), $urandom);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(index, data);
    endtask

    // The unused upper data bits of the size registers carry random noise.
    task automatic configure(bit [SIZE_W-1:0] w, bit [SIZE_W-1:0] h, bit [BASE_W-1:0] base);
        write_reg(CFG_TEX_WIDTH, {(CFG_DATA_W-SIZE_W)'($urandom), w});
        write_reg(CFG_TEX_HEIGHT, {(CFG_DATA_W-SIZE_W)'($urandom), h});
        write_reg(CFG_TEXEL_BASE, base);
        cfg_we <= 1'b0;
    endtask

    // Waits until every sample has answered. Writes give no answer, so a drain
    // margin follows before the registers may change under the block.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Coordinates favor the edges of the fraction and of the signed range.
    function automatic bit [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return {16'($urandom), 16'h0000};
            1: return {16'($urandom), 16'hFFFF};
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return -32'($urandom_range(1, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [SHIFT_W-1:0] rand_shift();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return SHIFT_W'($urandom);
        endcase
    endfunction

    // Mostly samples; some writes anywhere, some into the current texture so
    // that later samples see refreshed content.
    task automatic random_item(bit allow_toggle);
        int pick;
        pick = $urandom_range(0, 9);
        if (allow_toggle && $urandom_range(0, 59) == 0)
            idle_on = !idle_on;
        if (pick < 2)
            write_at(INDEX_W'($urandom), $urandom);
        else if (pick < 4)
            write_at(INDEX_W'(sb.base_reg + $urandom_range(0, sb.area() - 1)), $urandom);
        else
            sample_at(rand_coord(), rand_coord(), rand_shift(), rand_shift());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        int target;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_TEX_WIDTH;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        operation   <= OP_WRITE;
        u_coord     <= '0;
        v_coord     <= '0;
        shift_u     <= '0;
        shift_v     <= '0;
        write_index <= '0;
        write_texel <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a 1 x 1 texture at index 0, so every coordinate and
        // every offset must land on the same texel.
        write_at(16'h0000, 32'hFFFF_FFFF);
        write_at(16'hFFFF, 32'h0000_0000);
        sample_at(32'h0000_0000, 32'h0000_0000, 10'd0, 10'd0);
        sample_at(32'hFFFF_FFFF, 32'h8000_0000, 10'd1023, 10'd1023);
        sample_at(32'h7FFF_FFFF, 32'hFFFF_0000, 10'd0, 10'd1023);
        settle();

        // A 4 x 3 texture whose base sits two texels below the top of memory,
        // so the address wraps around to index 0 partway through.
        configure(9'd4, 9'd3, 16'hFFFE);
        for (int i = 0; i < 12; i++)
            write_at(INDEX_W'(16'hFFFE + i), $urandom);
        sample_at(32'h0000_FFFF, 32'h0000_FFFF, 10'd0, 10'd0);
        sample_at(32'hFFFF_FFFF, 32'h8000_0000, 10'd1023, 10'd1);
        sample_at(32'h0001_8000, 32'hFFFF_8000, 10'd5, 10'd0);
        sample_at(32'h8000_0000, 32'h7FFF_4000, 10'd2, 10'd1022);
        write_at(16'h0003, 32'h0000_0000);
        sample_at(32'h0000_0000, 32'h0000_AAAA, 10'd1, 10'd1);
        settle();

        // Random phases, each under its own texture settings; the extremes
        // come first. The last phase runs without any idling.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: configure(9'd256, 9'd256, 16'h0000);
                1: configure(9'd0, 9'd0, 16'hFFFF);
                2: configure(9'd511, 9'd300, BASE_W'($urandom));
                3: configure(9'd1, 9'd256, 16'hFFFF);
                4: configure(9'd256, 9'd1, BASE_W'($urandom));
                5: configure(9'd2, 9'd2, BASE_W'($urandom));
                6: configure(9'd255, 9'd257, BASE_W'($urandom));
                default: configure(SIZE_W'($urandom_range(0, 511)),
                                   SIZE_W'($urandom_range(0, 511)), BASE_W'($urandom));
            endcase
            idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            target = ITEM_TARGET * (phase + 1) / PHASES;
            while (items_sent < target)
                random_item(phase != PHASES - 1);
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("texture_wrap_nearest_sampler_core verification clean");
        else
            $display("texture_wrap_nearest_sampler_core verification failed");
        $finish;
    end

endmodule
